>>> rtl/core/vnu_pkg.sv
package vnu_pkg;

	// Fixed field widths
	localparam int COMP_W = 16;
	localparam int IN_FRAC = 8;
	localparam int UNIT_FRAC = 14;
	localparam int MAG_W = 32;
	localparam int SQ_W = 64;
	localparam int ROOT_W = 32;
	localparam int Q_W = 15;
	localparam int UNIT_W = 16;

	// Pipeline depth
	localparam int FRONT_STAGES = 4;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES = Q_W;
	localparam int LATENCY = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;

	// Per-lane data carried alongside the root
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
	} side_t;

	// Magnitude of a 33-bit two's complement value
	function automatic logic [MAG_W-1:0] abs33(input logic [MAG_W:0] v);
		logic [MAG_W:0] t;
		t = v[MAG_W] ? (~v + {{MAG_W{1'b0}}, 1'b1}) : v;
		return t[MAG_W-1:0];
	endfunction

endpackage

>>> rtl/core/vnu_sqrt_pipe.sv
module vnu_sqrt_pipe (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  logic [63:0]            in_sq,
	input  vnu_pkg::side_t         in_side,
	output logic                   out_vld,
	output logic [31:0]            out_root,
	output vnu_pkg::side_t         out_side
);
	import vnu_pkg::*;

	// one root bit per stage, index k holds the result of stage k
	logic                vld_s  [1:SQRT_STAGES];
	logic [ROOT_W+1:0]   rem_s  [1:SQRT_STAGES];
	logic [ROOT_W-1:0]   root_s [1:SQRT_STAGES];
	logic [SQ_W-1:0]     x_s    [1:SQRT_STAGES];
	side_t               side_s [1:SQRT_STAGES];

	for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_stage
		logic              p_vld;
		logic [ROOT_W+1:0] p_rem;
		logic [ROOT_W-1:0] p_root;
		logic [SQ_W-1:0]   p_x;
		side_t             p_side;
		logic [ROOT_W+3:0] cur;
		logic [ROOT_W+3:0] trial;
		logic              ge;

		if (k == 1) begin : g_first
			assign p_vld  = in_vld;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_x    = in_sq;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_x    = x_s[k-1];
			assign p_side = side_s[k-1];
		end

		// bring down two radicand bits, try (root << 2) | 1
		assign cur   = {p_rem, p_x[SQ_W-1:SQ_W-2]};
		assign trial = {2'b00, p_root, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else vld_s[k] <= p_vld;
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? (cur[ROOT_W+1:0] - trial[ROOT_W+1:0]) : cur[ROOT_W+1:0];
			root_s[k] <= {p_root[ROOT_W-2:0], ge};
			x_s[k]    <= {p_x[SQ_W-3:0], 2'b00};
			side_s[k] <= p_side;
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES];
	assign out_root = root_s[SQRT_STAGES];
	assign out_side = side_s[SQRT_STAGES];

endmodule

>>> rtl/core/vnu_div_pipe.sv
module vnu_div_pipe (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  logic [31:0]            in_len,
	input  vnu_pkg::side_t         in_side,
	output logic                   out_vld,
	output logic [2:0][15:0]       out_unit,
	output logic [31:0]            out_len,
	output logic                   out_zero
);
	import vnu_pkg::*;

	// control and divisor, shared by the three lanes
	logic              vld_s  [1:DIV_STAGES];
	logic [ROOT_W-1:0] len_s  [1:DIV_STAGES];
	logic [2:0]        neg_s  [1:DIV_STAGES];

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_ctl
		logic              p_vld;
		logic [ROOT_W-1:0] p_len;
		logic [2:0]        p_neg;
		if (k == 1) begin : g_first
			assign p_vld = in_vld;
			assign p_len = in_len;
			assign p_neg = in_side.neg;
		end else begin : g_next
			assign p_vld = vld_s[k-1];
			assign p_len = len_s[k-1];
			assign p_neg = neg_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else vld_s[k] <= p_vld;
		end
		always_ff @(posedge clk) begin
			len_s[k] <= p_len;
			neg_s[k] <= p_neg;
		end
	end

	// one restoring divider per lane, one quotient bit per stage
	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [ROOT_W-1:0] rem_s [1:DIV_STAGES];
		logic [Q_W-1:0]    low_s [1:DIV_STAGES];
		logic [Q_W-1:0]    q_s   [1:DIV_STAGES];
		logic [UNIT_W-1:0] qx;

		for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
			logic [ROOT_W-1:0] p_rem;
			logic [Q_W-1:0]    p_low;
			logic [Q_W-1:0]    p_q;
			logic [ROOT_W-1:0] p_len;
			logic [ROOT_W:0]   cur;
			logic              ge;

			// dividend is mag << 14; the top part already sits below len
			if (k == 1) begin : g_first
				assign p_rem = {1'b0, in_side.mag[i][MAG_W-1:1]};
				assign p_low = {in_side.mag[i][0], {(Q_W-1){1'b0}}};
				assign p_q   = '0;
				assign p_len = in_len;
			end else begin : g_next
				assign p_rem = rem_s[k-1];
				assign p_low = low_s[k-1];
				assign p_q   = q_s[k-1];
				assign p_len = len_s[k-1];
			end

			assign cur = {p_rem, p_low[Q_W-1]};
			assign ge  = (cur >= {1'b0, p_len});

			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? (cur[ROOT_W-1:0] - p_len) : cur[ROOT_W-1:0];
				low_s[k] <= {p_low[Q_W-2:0], 1'b0};
				q_s[k]   <= {p_q[Q_W-2:0], ge};
			end
		end

		// restore sign, zero vector gives zero
		assign qx = {1'b0, q_s[DIV_STAGES][DIV_STAGES-1:0]};
		assign out_unit[i] = (len_s[DIV_STAGES] == '0) ? '0 :
			(neg_s[DIV_STAGES][i] ? (~qx + {{(UNIT_W-1){1'b0}}, 1'b1}) : qx);
	end

	assign out_vld  = vld_s[DIV_STAGES];
	assign out_len  = len_s[DIV_STAGES];
	assign out_zero = (len_s[DIV_STAGES] == '0);

endmodule

>>> rtl/core/vector3_normalize_unit.sv
// Throughput: one item per cycle; busy never rises (4 front stages for
// products, cross, squares and sum, 32 root stages, 15 divider stages).
// Reset: arst_n clears all stage valid bits at once; data registers hold.
// The receiver cannot stall, so results leave on the done strobe.
module vector3_normalize_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [15:0] a_x,
	input  logic [15:0] a_y,
	input  logic [15:0] a_z,
	input  logic [15:0] b_x,
	input  logic [15:0] b_y,
	input  logic [15:0] b_z,
	output logic        done,
	output logic [15:0] unit_x,
	output logic [15:0] unit_y,
	output logic [15:0] unit_z,
	output logic [31:0] length,
	output logic        zero_length
);
	import vnu_pkg::*;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic                   func_s1;
	logic [2:0][COMP_W-1:0] a_s1;
	logic [5:0][MAG_W-1:0]  p_s1;
	logic [2:0][MAG_W:0]    v;
	logic [2:0][MAG_W-1:0]  a_abs;
	side_t                  side_c, side_s2, side_s3, side_s4;
	logic [2:0][SQ_W-1:0]   sqr_s3;
	logic [SQ_W-1:0]        sq_s4;

	logic                   rt_vld;
	logic [ROOT_W-1:0]      rt_root;
	side_t                  rt_side;
	logic [2:0][UNIT_W-1:0] unit;

	assign busy = 1'b0;

	// valid chain of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: cross product partial products
	always_ff @(posedge clk) begin
		func_s1 <= func;
		a_s1    <= {a_z, a_y, a_x};
		p_s1[0] <= MAG_W'($signed(a_y)) * MAG_W'($signed(b_z));
		p_s1[1] <= MAG_W'($signed(a_z)) * MAG_W'($signed(b_y));
		p_s1[2] <= MAG_W'($signed(a_z)) * MAG_W'($signed(b_x));
		p_s1[3] <= MAG_W'($signed(a_x)) * MAG_W'($signed(b_z));
		p_s1[4] <= MAG_W'($signed(a_x)) * MAG_W'($signed(b_y));
		p_s1[5] <= MAG_W'($signed(a_y)) * MAG_W'($signed(b_x));
	end

	// stage 2: selected vector, sign and magnitude in Q16.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v[i] = {p_s1[2*i][MAG_W-1], p_s1[2*i]}
				- {p_s1[2*i+1][MAG_W-1], p_s1[2*i+1]};
			a_abs[i] = abs33({{(MAG_W+1-COMP_W){a_s1[i][COMP_W-1]}}, a_s1[i]});
			if (!func_s1) begin
				side_c.neg[i] = a_s1[i][COMP_W-1];
				side_c.mag[i] = {a_abs[i][MAG_W-IN_FRAC-1:0], {IN_FRAC{1'b0}}};
			end else begin
				side_c.neg[i] = v[i][MAG_W];
				side_c.mag[i] = abs33(v[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_c;
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sqr_s3[i] <= side_s2.mag[i] * side_s2.mag[i];
		end
		side_s3 <= side_s2;
	end

	// stage 4: sum of squares in Q32.32
	always_ff @(posedge clk) begin
		sq_s4   <= sqr_s3[0] + sqr_s3[1] + sqr_s3[2];
		side_s4 <= side_s3;
	end

	vnu_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.in_sq    (sq_s4),
		.in_side  (side_s4),
		.out_vld  (rt_vld),
		.out_root (rt_root),
		.out_side (rt_side)
	);

	vnu_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (rt_vld),
		.in_len   (rt_root),
		.in_side  (rt_side),
		.out_vld  (done),
		.out_unit (unit),
		.out_len  (length),
		.out_zero (zero_length)
	);

	assign unit_x = unit[0];
	assign unit_y = unit[1];
	assign unit_z = unit[2];

endmodule

>>> rtl/core/vnu_checker.sv
module vnu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        func,
	input logic [15:0] a_x,
	input logic [15:0] a_y,
	input logic [15:0] a_z,
	input logic [15:0] b_x,
	input logic [15:0] b_y,
	input logic [15:0] b_z,
	input logic        done,
	input logic [15:0] unit_x,
	input logic [15:0] unit_y,
	input logic [15:0] unit_z,
	input logic [31:0] length,
	input logic        zero_length
);
	import vnu_pkg::*;

	// every transfer in yields one result
	a_lat_in: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted item");

	// no result without a transfer in
	a_lat_none: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done)
		else $error("result without accepted item");

	// zero magnitude gives a zero vector
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_length) |->
		(length == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0))
		else $error("zero length with nonzero output");

	// flag follows the length, units stay within one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !zero_length) |-> (length != '0
		&& $signed(unit_x) <= 16'sd16384 && $signed(unit_x) >= -16'sd16384
		&& $signed(unit_y) <= 16'sd16384 && $signed(unit_y) >= -16'sd16384
		&& $signed(unit_z) <= 16'sd16384 && $signed(unit_z) >= -16'sd16384))
		else $error("unit component out of range");

endmodule

bind vector3_normalize_unit vnu_checker u_vnu_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	// Normalized result of one vector
	typedef struct {
		logic [15:0] ux;
		logic [15:0] uy;
		logic [15:0] uz;
		logic [31:0] len;
		logic        zl;
	} unit_res_t;

	typedef enum logic {
		FN_NORM  = 1'b0,
		FN_CROSS = 1'b1
	} fn_e;

	localparam int DRAIN_CYCLES = vnu_pkg::LATENCY + 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        func = 1'b0;
	logic [15:0] a_x = '0, a_y = '0, a_z = '0;
	logic [15:0] b_x = '0, b_y = '0, b_z = '0;
	logic        done;
	logic [15:0] unit_x, unit_y, unit_z;
	logic [31:0] length;
	logic        zero_length;

	unit_res_t exp_q[$];
	int        n_err = 0;
	int        burst_left = 0;

	vector3_normalize_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.length(length), .zero_length(zero_length)
	);

	always #5 clk = ~clk;

	// Floor square root, bit by bit
	function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
		logic [63:0] rem, root, bitv;
		rem = x;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Expected magnitude and unit vector for one transfer
	function automatic unit_res_t normalize_vec(input fn_e f,
			input logic signed [15:0] ax, ay, az, bx, by, bz);
		logic signed [63:0] v[3];
		logic [63:0] mag[3];
		logic [63:0] sq, len, q;
		unit_res_t r;
		sq = '0;
		if (f == FN_NORM) begin
			v[0] = ax; v[1] = ay; v[2] = az;
			for (int i = 0; i < 3; i++) begin
				mag[i] = (v[i] < 0) ? -v[i] : v[i];
				sq += mag[i] * mag[i];
				mag[i] = mag[i] << 8;
			end
			sq <<= 16;
		end else begin
			v[0] = 64'(ay) * bz - 64'(az) * by;
			v[1] = 64'(az) * bx - 64'(ax) * bz;
			v[2] = 64'(ax) * by - 64'(ay) * bx;
			for (int i = 0; i < 3; i++) begin
				mag[i] = (v[i] < 0) ? -v[i] : v[i];
				sq += mag[i] * mag[i];
			end
		end
		len = sqrt_floor(sq);
		r = '{16'd0, 16'd0, 16'd0, 32'd0, 1'b1};
		if (len != 0) begin
			r.zl = 1'b0;
			r.len = len[31:0];
			for (int i = 0; i < 3; i++) begin
				q = (mag[i] << 14) / len;
				if (v[i] < 0)
					q = -q;
				if (i == 0) r.ux = q[15:0];
				else if (i == 1) r.uy = q[15:0];
				else r.uz = q[15:0];
			end
		end
		return r;
	endfunction

	// Send one item; sender works in random bursts with gaps
	task automatic send_vec(input fn_e f, input logic [15:0] ax, ay, az, bx, by, bz);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		func <= f;
		a_x <= ax; a_y <= ay; a_z <= az;
		b_x <= bx; b_y <= by; b_z <= bz;
		do @(posedge clk); while (busy);
		exp_q.push_back(normalize_vec(f, ax, ay, az, bx, by, bz));
		@(negedge clk);
	endtask

	// Result check
	always @(posedge clk) begin
		unit_res_t e;
		if (arst_n && done) begin
			if (exp_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result len=%h", length);
			end else begin
				e = exp_q.pop_front();
				if (unit_x !== e.ux || unit_y !== e.uy || unit_z !== e.uz ||
						length !== e.len || zero_length !== e.zl) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
							e.ux, e.uy, e.uz, e.len, e.zl,
							unit_x, unit_y, unit_z, length, zero_length);
				end
			end
		end
	end

	function automatic logic [15:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// Stop sending and wait for every outstanding result
	task automatic wait_drained();
		start <= 1'b0;
		while (exp_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_norm_directed();
		send_vec(FN_NORM, 0, 0, 0, 16'h1234, 1, 2);
		send_vec(FN_NORM, 16'h0100, 0, 0, 0, 0, 0);
		send_vec(FN_NORM, 0, 16'hff00, 0, 0, 0, 0);
		send_vec(FN_NORM, 0, 0, 16'h0001, 0, 0, 0);
		send_vec(FN_NORM, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
		send_vec(FN_NORM, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 0, 0);
		send_vec(FN_NORM, 16'h8000, 16'h7fff, 16'h0001, 0, 0, 0);
		send_vec(FN_NORM, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0);
		send_vec(FN_NORM, 16'h0300, 16'h0400, 0, 0, 0, 0);
	endtask

	task automatic test_cross_directed();
		send_vec(FN_CROSS, 0, 0, 0, 16'h7fff, 16'h8000, 1);
		send_vec(FN_CROSS, 16'h0100, 16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300);
		send_vec(FN_CROSS, 16'h0100, 0, 0, 0, 16'h0100, 0);
		send_vec(FN_CROSS, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_vec(FN_CROSS, 16'h8000, 0, 0, 0, 16'h8000, 0);
		send_vec(FN_CROSS, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_vec(FN_CROSS, 1, 0, 0, 0, 1, 0);
		send_vec(FN_CROSS, 16'hffff, 16'hffff, 0, 16'h0001, 16'hffff, 0);
	endtask

	// Sender holds off until the pipeline is empty
	task automatic test_drain_pause();
		wait_drained();
		repeat (3) @(negedge clk);
		send_vec(FN_NORM, 16'h0001, 16'h0002, 16'h0003, 0, 0, 0);
	endtask

	task automatic test_random(input int n);
		fn_e f;
		logic [15:0] c[6];
		for (int k = 0; k < n; k++) begin
			f = fn_e'($urandom_range(0, 1));
			foreach (c[i])
				c[i] = rnd_comp();
			// parallel vectors for a zero cross product now and then
			if (f == FN_CROSS && $urandom_range(0, 15) == 0) begin
				c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
			end
			send_vec(f, c[0], c[1], c[2], c[3], c[4], c[5]);
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_norm_directed();
		test_cross_directed();
		test_drain_pause();
		test_random(900);
		test_drain_pause();
		test_random(850);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_err == 0 && exp_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
